// File: rtl/xep_pkg.sv
// Shared types and constants for the cross-reference entry parser.
`timescale 1ns / 1ps

package xep_pkg;

    // Record geometry
    localparam int unsigned RecLen  = 20;
    localparam int unsigned PosW    = 5;
    localparam int unsigned OfsW    = 34;
    localparam int unsigned GenW    = 17;
    localparam int unsigned StatusW = 3;
    localparam int unsigned OutW    = 64;

    // Byte positions of interest
    localparam logic [PosW-1:0] POS_OFS_LAST = 5'd9;
    localparam logic [PosW-1:0] POS_SP10     = 5'd10;
    localparam logic [PosW-1:0] POS_GEN_LAST = 5'd15;
    localparam logic [PosW-1:0] POS_SP16     = 5'd16;
    localparam logic [PosW-1:0] POS_USE      = 5'd17;
    localparam logic [PosW-1:0] POS_EIGHTEEN = 5'd18;
    localparam logic [PosW-1:0] POS_LAST     = 5'd19;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Status codes
    localparam logic [StatusW-1:0] ST_OK          = 3'd0;
    localparam logic [StatusW-1:0] ST_BAD_TERM    = 3'd1;
    localparam logic [StatusW-1:0] ST_OFS_NODIGIT = 3'd2;
    localparam logic [StatusW-1:0] ST_NO_SP10     = 3'd3;
    localparam logic [StatusW-1:0] ST_GEN_NODIGIT = 3'd4;
    localparam logic [StatusW-1:0] ST_NO_SP16     = 3'd5;
    localparam logic [StatusW-1:0] ST_USE_BLANK   = 3'd6;

    // Structural check flags gathered while a record streams by
    typedef struct packed {
        logic use_ok;
        logic sp16;
        logic gen_digit;
        logic sp10;
        logic ofs_digit;
    } t_checks;

    // One parsed entry
    typedef struct packed {
        logic [7:0]         use_char;
        logic [GenW-1:0]    generation_number;
        logic [OfsW-1:0]    object_offset;
        logic [StatusW-1:0] status;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

// File: rtl/xref_entry_parser_top.sv
// Top level of the cross-reference entry parser: byte stream in, parsed entries out.
`timescale 1ns / 1ps
// Throughput: one byte per cycle while the result side takes results.
// Latency: the parsed entry is valid the cycle after byte 19 of a record is accepted.
// Each byte updates the accumulators with one multiply-by-ten add; the result
// register holds one entry and input is stalled only while it is full and not taken.
// Reset (synchronous, active low) sets the byte position to zero, clears all
// record state and empties the result register.

module xref_entry_parser_top
    import xep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tuser,   // [0] record_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OutW-1:0]   m_axis_tdata    // [2:0] status, [36:3] object_offset,
                                              // [53:37] generation_number,
                                              // [61:54] use_char, [63:62] zero
);

    logic [PosW-1:0] r_pos, n_pos;
    logic [OfsW-1:0] r_ofs, n_ofs;
    logic            r_ofs_end, n_ofs_end;
    logic [GenW-1:0] r_gen, n_gen;
    logic            r_gen_end, n_gen_end;
    t_checks         r_chk, n_chk;
    logic [7:0]      r_use, n_use;
    logic [7:0]      r_b18, n_b18;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    logic            w_accept;
    logic [PosW-1:0] w_pos;
    logic            w_first;
    logic            w_dig;
    logic [7:0]      w_b;
    logic [OfsW-1:0] w_ofs_base;
    logic [GenW-1:0] w_gen_base;
    logic            w_term_ok;
    logic [StatusW-1:0] w_status;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_b           = s_axis_tdata;
    assign w_pos         = s_axis_tuser ? '0 : r_pos;
    assign w_first       = (w_pos == '0);
    assign w_dig         = is_digit(w_b);
    assign w_ofs_base    = w_first ? '0 : r_ofs;
    assign w_gen_base    = w_first ? '0 : r_gen;

    // Update record state for the byte on the input
    always_comb begin
        n_pos     = (w_pos == POS_LAST) ? '0 : w_pos + 1'b1;
        n_ofs     = w_ofs_base;
        n_ofs_end = w_first ? 1'b0 : r_ofs_end;
        n_gen     = w_gen_base;
        n_gen_end = w_first ? 1'b0 : r_gen_end;
        n_chk     = w_first ? '0 : r_chk;
        n_use     = w_first ? '0 : r_use;
        n_b18     = w_first ? '0 : r_b18;
        if (w_pos <= POS_OFS_LAST) begin
            if (!n_ofs_end && w_dig) begin
                n_ofs = (w_ofs_base << 3) + (w_ofs_base << 1) + OfsW'(w_b[3:0]);
            end else begin
                n_ofs_end = 1'b1;
            end
            if (w_first && w_dig) n_chk.ofs_digit = 1'b1;
        end else if (w_pos == POS_SP10) begin
            if (w_b == CH_SPACE) n_chk.sp10 = 1'b1;
        end else if (w_pos <= POS_GEN_LAST) begin
            if (!n_gen_end && w_dig) begin
                n_gen = (w_gen_base << 3) + (w_gen_base << 1) + GenW'(w_b[3:0]);
            end else begin
                n_gen_end = 1'b1;
            end
            if ((w_pos == POS_SP10 + 1'b1) && w_dig) n_chk.gen_digit = 1'b1;
        end else if (w_pos == POS_SP16) begin
            if (w_b == CH_SPACE) n_chk.sp16 = 1'b1;
        end else if (w_pos == POS_USE) begin
            n_use = w_b;
            if (w_b != CH_SPACE) n_chk.use_ok = 1'b1;
        end else if (w_pos == POS_EIGHTEEN) begin
            n_b18 = w_b;
        end
    end

    // Check the terminator and pick the first failing check
    always_comb begin
        w_term_ok = ((r_b18 == CH_SPACE) && ((w_b == CH_CR) || (w_b == CH_LF))) ||
                    ((r_b18 == CH_CR) && (w_b == CH_LF));
        if (!w_term_ok)             w_status = ST_BAD_TERM;
        else if (!r_chk.ofs_digit)  w_status = ST_OFS_NODIGIT;
        else if (!r_chk.sp10)       w_status = ST_NO_SP10;
        else if (!r_chk.gen_digit)  w_status = ST_GEN_NODIGIT;
        else if (!r_chk.sp16)       w_status = ST_NO_SP16;
        else if (!r_chk.use_ok)     w_status = ST_USE_BLANK;
        else                        w_status = ST_OK;
    end

    // Load the result register on the last byte, drop valid when taken
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        if (w_accept && (w_pos == POS_LAST)) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.status = w_status;
            if (w_status == ST_OK) begin
                n_out.object_offset     = r_ofs;
                n_out.generation_number = r_gen;
                n_out.use_char          = r_use;
            end
        end
    end

    // Control and record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_ofs       <= '0;
            r_ofs_end   <= 1'b0;
            r_gen       <= '0;
            r_gen_end   <= 1'b0;
            r_chk       <= '0;
            r_use       <= '0;
            r_b18       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_pos     <= n_pos;
                r_ofs     <= n_ofs;
                r_ofs_end <= n_ofs_end;
                r_gen     <= n_gen;
                r_gen_end <= n_gen_end;
                r_chk     <= n_chk;
                r_use     <= n_use;
                r_b18     <= n_b18;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutW'(r_out);

endmodule

// File: rtl/xep_checker.sv
// Port-level checks for the cross-reference entry parser, bound to the top level.
`timescale 1ns / 1ps

module xep_checker
    import xep_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            s_axis_tvalid,
    input logic            s_axis_tready,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [OutW-1:0] m_axis_tdata
);

    // Hold a pending result until the transaction completes
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // A new result needs an input transaction in the cycle before
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without input transaction");

    // Error results carry zero value fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK) |-> (m_axis_tdata[OutW-1:3] == '0))
        else $error("error result with nonzero fields");

    // A good entry never has a blank use character, and status stays in range
    a_ok_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7) &&
            ((m_axis_tdata[2:0] != ST_OK) || (m_axis_tdata[61:54] != CH_SPACE)))
        else $error("bad status or blank use character on good entry");

endmodule

bind xref_entry_parser_top xep_checker u_xep_checker (.*);

// File: verif/tb_top.sv
// Self-checking bench for the cross-reference entry parser: byte stream in, parsed entries out.
`timescale 1ns / 1ps

module tb_top;
    import xep_pkg::*;

    localparam int unsigned IdleLimit  = 3000;
    localparam int unsigned LongHold   = 400;
    localparam int unsigned TargetByte = 1400;

    // Terminator styles of a well-formed entry
    localparam int unsigned TERM_SP_CR = 0;
    localparam int unsigned TERM_SP_LF = 1;
    localparam int unsigned TERM_CRLF  = 2;

    typedef logic [7:0] t_entry_bytes [RecLen];

    // Predict parsed entries from the byte stream and check the entries that come out
    class xref_entry_checker;
        t_result           expected_entries[$];
        int                errors;
        logic [PosW-1:0]   pos;
        logic [OfsW-1:0]   ofs_acc;
        bit                ofs_done;
        logic [GenW-1:0]   gen_acc;
        bit                gen_done;
        t_checks           flags;
        logic [7:0]        use_byte;
        logic [7:0]        term_first;

        function new();
            errors = 0;
            pos = '0;
            start_entry();
        endfunction

        function void start_entry();
            ofs_acc    = '0;
            ofs_done   = 1'b0;
            gen_acc    = '0;
            gen_done   = 1'b0;
            flags      = '0;
            use_byte   = '0;
            term_first = '0;
        endfunction

        function bit is_dec(logic [7:0] b);
            return (b >= 8'h30) && (b <= 8'h39);
        endfunction

        // Advance the record state by one accepted byte
        function void note_byte(logic [7:0] b, logic start);
            t_result e;
            bit      term_ok;
            if (start) pos = '0;
            if (pos == '0) start_entry();

            if (pos <= POS_OFS_LAST) begin
                if (!ofs_done && is_dec(b))
                    ofs_acc = OfsW'(ofs_acc * 34'd10 + OfsW'(b - CH_ZERO));
                else
                    ofs_done = 1'b1;
                if (pos == '0 && is_dec(b)) flags.ofs_digit = 1'b1;
            end else if (pos == POS_SP10) begin
                if (b == CH_SPACE) flags.sp10 = 1'b1;
            end else if (pos <= POS_GEN_LAST) begin
                if (!gen_done && is_dec(b))
                    gen_acc = GenW'(gen_acc * 17'd10 + GenW'(b - CH_ZERO));
                else
                    gen_done = 1'b1;
                if (pos == POS_SP10 + 1 && is_dec(b)) flags.gen_digit = 1'b1;
            end else if (pos == POS_SP16) begin
                if (b == CH_SPACE) flags.sp16 = 1'b1;
            end else if (pos == POS_USE) begin
                use_byte = b;
                if (b != CH_SPACE) flags.use_ok = 1'b1;
            end else if (pos == POS_EIGHTEEN) begin
                term_first = b;
            end

            if (pos != POS_LAST) begin
                pos = pos + 1'b1;
                return;
            end

            // Byte 19 closes the entry: first failing check wins
            pos = '0;
            term_ok = (term_first == CH_SPACE && (b == CH_CR || b == CH_LF)) ||
                      (term_first == CH_CR && b == CH_LF);
            e = '0;
            if (!term_ok)              e.status = ST_BAD_TERM;
            else if (!flags.ofs_digit) e.status = ST_OFS_NODIGIT;
            else if (!flags.sp10)      e.status = ST_NO_SP10;
            else if (!flags.gen_digit) e.status = ST_GEN_NODIGIT;
            else if (!flags.sp16)      e.status = ST_NO_SP16;
            else if (!flags.use_ok)    e.status = ST_USE_BLANK;
            else                       e.status = ST_OK;
            if (e.status == ST_OK) begin
                e.object_offset     = ofs_acc;
                e.generation_number = gen_acc;
                e.use_char          = use_byte;
            end
            expected_entries.insert(expected_entries.size(), e);
        endfunction

        function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        endfunction

        // Compare one received entry with the oldest prediction
        function void check_entry(logic [OutW-1:0] d);
            t_result e;
            t_result a;
            if (expected_entries.size() == 0) begin
                errors++;
                $display("%0t: unexpected entry %0h", $time, d);
                return;
            end
            e = expected_entries.pop_front();
            a = t_result'(d[$bits(t_result)-1:0]);
            if (a.status !== e.status) report("status", e.status, a.status);
            if (a.object_offset !== e.object_offset)
                report("object_offset", e.object_offset, a.object_offset);
            if (a.generation_number !== e.generation_number)
                report("generation_number", e.generation_number, a.generation_number);
            if (a.use_char !== e.use_char) report("use_char", e.use_char, a.use_char);
            if (d[OutW-1:$bits(t_result)] !== '0)
                report("pad bits", 0, d[OutW-1:$bits(t_result)]);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] data_byte
    logic              s_axis_tuser = 1'b0; // [0] record_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OutW-1:0]   m_axis_tdata;        // [2:0] status, [36:3] object_offset,
                                            // [53:37] generation_number, [61:54] use_char

    xref_entry_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xref_entry_checker entry_chk = new();

    int unsigned bytes_sent   = 0;
    int unsigned entries_seen = 0;
    int unsigned idle_cycles  = 0;
    int unsigned rx_cycle     = 0;
    int unsigned rx_stall     = 0;
    int unsigned rx_hold      = 0;
    bit          long_hold_done = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly zero, sometimes short, rarely long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] rand_nondigit();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_NINE);
        return b;
    endfunction

    // Build a standard zero-padded entry
    function automatic t_entry_bytes make_entry(longint unsigned ofs, int unsigned gen,
                                                logic [7:0] use_c, int unsigned term);
        t_entry_bytes r;
        for (int i = 9; i >= 0; i--) begin
            r[i] = CH_ZERO + 8'(ofs % 10);
            ofs = ofs / 10;
        end
        r[10] = CH_SPACE;
        for (int i = 15; i >= 11; i--) begin
            r[i] = CH_ZERO + 8'(gen % 10);
            gen = gen / 10;
        end
        r[16] = CH_SPACE;
        r[17] = use_c;
        r[18] = (term == TERM_CRLF) ? CH_CR : CH_SPACE;
        r[19] = (term == TERM_SP_CR) ? CH_CR : CH_LF;
        return r;
    endfunction

    // Offer one byte, hold it until taken, then sometimes idle for a while
    task automatic push_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        entry_chk.note_byte(b, start);
        bytes_sent++;
        gap = ((bytes_sent / 150) % 3 == 2) ? 0 : gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_entry(input t_entry_bytes r, input logic start, input int unsigned n);
        for (int i = 0; i < n; i++)
            push_byte(r[i], (i == 0) ? start : 1'b0);
    endtask

    // Take results with random stalls and one long hold-off
    always @(posedge i_clk) begin
        rx_cycle++;
        if (m_axis_tvalid && m_axis_tready) begin
            entry_chk.check_entry(m_axis_tdata);
            entries_seen++;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && entries_seen == 30) begin
            long_hold_done = 1'b1;
            rx_hold = LongHold;
            m_axis_tready <= 1'b0;
        end else if (rx_cycle[8]) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall != 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall = gap_len();
            m_axis_tready <= (rx_stall == 0);
        end
    end

    // Stop the run when no transaction happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_entry_bytes    r;
        longint unsigned ofs;
        int unsigned     kind;
        int unsigned     k;
        int unsigned     n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each status, short runs, realignment
        send_entry(make_entry(0, 0, "f", TERM_SP_CR), 1'b1, RecLen);
        send_entry(make_entry(64'd9999999999, 99999, "n", TERM_SP_LF), 1'b1, RecLen);
        send_entry(make_entry(64'd1234567890, 12345, 8'hFF, TERM_CRLF), 1'b1, RecLen);
        r = make_entry(42, 1, "n", TERM_CRLF);
        r[18] = CH_LF;
        r[19] = CH_CR;
        send_entry(r, 1'b1, RecLen);
        r = make_entry(42, 1, "n", TERM_SP_LF);
        r[0] = 8'h80;
        send_entry(r, 1'b1, RecLen);
        r = make_entry(42, 1, "n", TERM_SP_LF);
        r[10] = CH_ZERO;
        send_entry(r, 1'b1, RecLen);
        r = make_entry(42, 1, "n", TERM_SP_LF);
        r[11] = 8'h2F;
        send_entry(r, 1'b1, RecLen);
        r = make_entry(42, 1, "n", TERM_SP_LF);
        r[15] = 8'h3A;
        r[16] = "x";
        send_entry(r, 1'b1, RecLen);
        r = make_entry(42, 1, CH_SPACE, TERM_SP_LF);
        send_entry(r, 1'b1, RecLen);
        r = make_entry(12, 7, "n", TERM_SP_CR);
        r[0] = "1";
        r[1] = "2";
        for (int i = 2; i <= 9; i++) r[i] = CH_SPACE;
        r[11] = "7";
        for (int i = 12; i <= 15; i++) r[i] = CH_SPACE;
        send_entry(r, 1'b1, RecLen);
        // drop a partial entry, then a full one with the start flag and one that follows without it
        send_entry(make_entry(777, 3, "n", TERM_CRLF), 1'b1, 7);
        send_entry(make_entry(555, 2, "f", TERM_CRLF), 1'b1, RecLen);
        send_entry(make_entry(31, 4, "n", TERM_SP_CR), 1'b0, RecLen);
        for (int i = 0; i < RecLen; i++) r[i] = 8'h00;
        send_entry(r, 1'b1, RecLen);

        // Random: mostly well-formed entries, some corrupted, truncated or noise
        while (bytes_sent < TargetByte) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                n = $urandom_range(1, 25);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                ofs = longint'($urandom_range(0, 99999)) * 100000 + $urandom_range(0, 99999);
                r = make_entry(ofs, $urandom_range(0, 99999),
                               ($urandom_range(0, 4) != 0) ?
                                   (($urandom_range(0, 1) != 0) ? 8'h6E : 8'h66) :
                                   8'($urandom_range(0, 255)),
                               $urandom_range(TERM_SP_CR, TERM_CRLF));
                if ($urandom_range(0, 9) < 4) begin
                    k = $urandom_range(1, 10);
                    for (int i = k; i <= 9; i++)
                        r[i] = ($urandom_range(0, 1) != 0) ? CH_SPACE : rand_nondigit();
                end
                if ($urandom_range(0, 9) < 4) begin
                    k = $urandom_range(12, 16);
                    for (int i = k; i <= 15; i++)
                        r[i] = ($urandom_range(0, 1) != 0) ? CH_SPACE : rand_nondigit();
                end
                if ($urandom_range(0, 9) < 3) begin
                    n = $urandom_range(1, 2);
                    for (int i = 0; i < n; i++)
                        r[$urandom_range(0, RecLen - 1)] = 8'($urandom_range(0, 255));
                end
                n = (kind < 15) ? $urandom_range(1, RecLen - 1) : RecLen;
                send_entry(r, $urandom_range(0, 9) != 0, n);
            end
        end

        // Drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (entry_chk.expected_entries.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (entry_chk.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/xep_pkg.sv
rtl/xref_entry_parser_top.sv
rtl/xep_checker.sv
verif/tb_top.sv
